// ----- rtl/hdlc_stuff_nrzi_tx_framer_macros.svh -----
// ----------------------------------------------------------------------------
// HDLC transmit framer assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as reset.
// ----------------------------------------------------------------------------
`ifndef HDLC_STUFF_NRZI_TX_FRAMER_MACROS_SVH
`define HDLC_STUFF_NRZI_TX_FRAMER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HDLC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HDLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hdlc_pkg.sv -----
// ----------------------------------------------------------------------------
// HDLC transmit framer package
// Shared types and line sequence constants.
// ----------------------------------------------------------------------------
package hdlc_pkg;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // preamble: start level, 3 ramp ones, 24 training bits, flag (LSB first)
    localparam int PRE_LEN = 36;
    localparam logic [PRE_LEN-1:0] PRE_SEQ = {8'h7e, 24'h555555, 3'b111, 1'b1};

    // closing: flag MSB first, then 3 ramp-down zeros
    localparam int CLOSE_LEN = 11;
    localparam logic [CLOSE_LEN-1:0] CLOSE_SEQ = {3'b000, 8'h7e};

    localparam logic [2:0] STUFF_AFTER = 3'd5;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       start;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRE   = 4'b0010,
        S_DATA  = 4'b0100,
        S_CLOSE = 4'b1000
    } phase_t;

endpackage

// ----- rtl/hdlc_front.sv -----
// ----------------------------------------------------------------------------
// HDLC framer front end
// Accepts octets and marks the first octet of each frame.
// ----------------------------------------------------------------------------
module hdlc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  hdlc_pkg::q_status_t q_status,
    output logic               q_wr,
    output hdlc_pkg::item_t    q_item
);
    import hdlc_pkg::*;

    logic in_frame_reg;
    logic in_frame_next;

    assign full = q_status.full;
    assign q_wr = push && !q_status.full;

    assign q_item.data  = data_byte;
    assign q_item.last  = last_byte;
    assign q_item.start = !in_frame_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        if (q_wr)
        begin
            in_frame_next = !last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// ----- rtl/hdlc_fifo.sv -----
// ----------------------------------------------------------------------------
// HDLC framer item queue
// Short queue decoupling the front end from the bit serializer.
// ----------------------------------------------------------------------------
module hdlc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  hdlc_pkg::item_t     wr_item,
    input  logic                rd,
    output hdlc_pkg::item_t     rd_item,
    output hdlc_pkg::q_status_t status
);
    import hdlc_pkg::*;

    item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_wr;
    logic               do_rd;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr && !status.full;
    assign do_rd = rd && !status.empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/hdlc_back.sv -----
// ----------------------------------------------------------------------------
// HDLC framer back end
// Serializes preamble, stuffed data and closing bits with NRZI coding.
// ----------------------------------------------------------------------------
`include "hdlc_stuff_nrzi_tx_framer_macros.svh"

module hdlc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hdlc_pkg::q_status_t q_status,
    input  hdlc_pkg::item_t     q_item,
    output logic                q_rd,
    output logic                empty,
    input  logic                pop,
    output logic                line_bit,
    output logic                frame_end
);
    import hdlc_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [5:0]  idx_reg;
    logic [5:0]  idx_next;
    logic        stuff_reg;
    logic        stuff_next;
    logic [2:0]  ones_reg;
    logic [2:0]  ones_next;
    logic        level_reg;
    logic        level_next;
    logic [7:0]  cur_data_reg;
    logic [7:0]  cur_data_next;
    logic        cur_last_reg;
    logic        cur_last_next;
    logic        out_valid_reg;
    logic        line_bit_reg;
    logic        frame_end_reg;

    logic        step;
    logic        emit;
    logic        raw_bit;
    logic        force_one;
    logic        fend;
    logic        load;
    logic [2:0]  ones_inc;

    assign empty     = !out_valid_reg;
    assign line_bit  = line_bit_reg;
    assign frame_end = frame_end_reg;
    assign step      = !out_valid_reg || pop;
    assign ones_inc  = ones_reg + 3'd1;
    assign level_next = !emit ? level_reg :
                        force_one ? 1'b1 :
                        raw_bit ? level_reg : !level_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        stuff_next    = stuff_reg;
        ones_next     = ones_reg;
        cur_data_next = cur_data_reg;
        cur_last_next = cur_last_reg;
        emit          = 1'b0;
        raw_bit       = 1'b1;
        force_one     = 1'b0;
        fend          = 1'b0;
        load          = 1'b0;
        q_rd          = 1'b0;

        if (step)
        begin
            unique case (phase_reg)
                S_IDLE:
                begin
                    load = 1'b1;
                end
                S_PRE:
                begin
                    emit      = 1'b1;
                    raw_bit   = PRE_SEQ[idx_reg];
                    force_one = (idx_reg == '0);
                    if (idx_reg == 6'(PRE_LEN - 1))
                    begin
                        phase_next = S_DATA;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                S_DATA:
                begin
                    emit = 1'b1;
                    if (stuff_reg)
                    begin
                        raw_bit    = 1'b0;
                        stuff_next = 1'b0;
                        if (idx_reg == 6'd8)
                        begin
                            load = !cur_last_reg;
                            if (cur_last_reg)
                            begin
                                phase_next = S_CLOSE;
                                idx_next   = '0;
                            end
                        end
                    end
                    else
                    begin
                        raw_bit  = cur_data_reg[idx_reg[2:0]];
                        idx_next = idx_reg + 6'd1;
                        if (raw_bit)
                        begin
                            if (ones_inc == STUFF_AFTER)
                            begin
                                ones_next  = '0;
                                stuff_next = 1'b1;
                            end
                            else
                            begin
                                ones_next = ones_inc;
                            end
                        end
                        else
                        begin
                            ones_next = '0;
                        end
                        // last data bit with no stuffed zero pending
                        if (idx_reg == 6'd7 && !(raw_bit && ones_inc == STUFF_AFTER))
                        begin
                            load = !cur_last_reg;
                            if (cur_last_reg)
                            begin
                                phase_next = S_CLOSE;
                                idx_next   = '0;
                            end
                        end
                    end
                end
                S_CLOSE:
                begin
                    emit    = 1'b1;
                    raw_bit = CLOSE_SEQ[idx_reg[3:0]];
                    if (idx_reg == 6'(CLOSE_LEN - 1))
                    begin
                        fend      = 1'b1;
                        ones_next = '0;
                        load      = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                default:
                begin
                    phase_next = S_IDLE;
                end
            endcase

            if (load)
            begin
                if (!q_status.empty)
                begin
                    q_rd          = 1'b1;
                    cur_data_next = q_item.data;
                    cur_last_next = q_item.last;
                    idx_next      = '0;
                    stuff_next    = 1'b0;
                    if (q_item.start)
                    begin
                        phase_next = S_PRE;
                        ones_next  = '0;
                    end
                    else
                    begin
                        phase_next = S_DATA;
                    end
                end
                else
                begin
                    phase_next = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= S_IDLE;
            idx_reg       <= '0;
            stuff_reg     <= 1'b0;
            ones_reg      <= '0;
            level_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            stuff_reg <= stuff_next;
            ones_reg  <= ones_next;
            level_reg <= level_next;
            if (step)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_data_reg <= cur_data_next;
        cur_last_reg <= cur_last_next;
        if (step)
        begin
            line_bit_reg  <= level_next;
            frame_end_reg <= fend;
        end
    end

    `HDLC_ASSERT_SAME(a_ones_below_stuff, 1'b1, ones_reg < STUFF_AFTER, "ones run reached stuff limit")
    `HDLC_ASSERT_SAME(a_stuff_in_data, stuff_reg, phase_reg == S_DATA, "stuff pending outside data")
    `HDLC_ASSERT_NEXT(a_start_level, step && phase_reg == S_PRE && idx_reg == '0, line_bit_reg, "start level not one")
    `HDLC_ASSERT_NEXT(a_stuff_toggles, step && phase_reg == S_DATA && stuff_reg, line_bit_reg != $past(level_reg), "stuffed zero did not toggle")
    `HDLC_ASSERT_SAME(a_rd_nonempty, q_rd, !q_status.empty, "queue read while empty")

endmodule

// ----- rtl/hdlc_stuff_nrzi_tx_framer.sv -----
// ----------------------------------------------------------------------------
// HDLC transmit framer with bit stuffing and NRZI coding
// Top level: front end, item queue and bit serializer.
// ----------------------------------------------------------------------------
// The framer emits one line bit per transaction on the result side, at up to
// one per cycle. A data octet costs 8 to 10 bit times (8 bits plus a stuffed
// zero after every fifth consecutive one); the first octet of a frame adds 36
// preamble bits and the last adds 11 closing bits, the final one flagged by
// frame_end. The rate is set by the serializer, which produces one bit per
// cycle into its output register while pop does not hold it back; a step
// that picks up an octet after running dry emits no bit. A two-entry queue
// lets octets be pushed while the serializer is still working on earlier ones.
module hdlc_stuff_nrzi_tx_framer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic       line_bit,
    output logic       frame_end
);
    import hdlc_pkg::*;

    q_status_t q_status;
    item_t     wr_item;
    item_t     rd_item;
    logic      q_wr;
    logic      q_rd;

    hdlc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_status  (q_status),
        .q_wr      (q_wr),
        .q_item    (wr_item)
    );

    hdlc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (wr_item),
        .rd      (q_rd),
        .rd_item (rd_item),
        .status  (q_status)
    );

    hdlc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_item    (rd_item),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .line_bit  (line_bit),
        .frame_end (frame_end)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HDLC transmit framer testbench
// Pushes frames of octets through the framer and checks every line bit and
// frame_end against a bit-level prediction of preamble, stuffing, closing
// and NRZI coding, with random idle bursts on both sides.
// ----------------------------------------------------------------------------

class line_scoreboard;

    localparam logic [7:0]  FLAG_OCTET   = 8'h7e;
    localparam logic [23:0] TRAIN_SEQ    = 24'h555555;
    localparam int          RAMP_BITS    = 3;
    localparam logic [2:0]  STUFF_LIMIT  = 3'd5;

    typedef struct packed {
        logic level;
        logic fend;
    } line_bit_t;

    line_bit_t  expected_bits[$];
    logic [2:0] ones_run;
    logic       level;
    logic       in_frame;
    int         errors;

    function new();
        ones_run = '0;
        level    = 1'b1;
        in_frame = 1'b0;
        errors   = 0;
    endfunction

    function void send_coded(logic b, logic fend);
        if (!b)
            level = ~level;
        expected_bits.push_back('{level: level, fend: fend});
    endfunction

    // one data bit, with a zero stuffed after the fifth one in a row
    function void send_data(logic b);
        send_coded(b, 1'b0);
        if (b)
        begin
            ones_run = ones_run + 3'd1;
            if (ones_run >= STUFF_LIMIT)
            begin
                send_coded(1'b0, 1'b0);
                ones_run = '0;
            end
        end
        else
            ones_run = '0;
    endfunction

    // accepted input transaction: expand into the line bits it causes
    function void note_octet(logic [7:0] octet, logic last);
        if (!in_frame)
        begin
            in_frame = 1'b1;
            ones_run = '0;
            level    = 1'b1;
            expected_bits.push_back('{level: 1'b1, fend: 1'b0});
            for (int k = 0; k < RAMP_BITS; k++)
                send_coded(1'b1, 1'b0);
            for (int k = 0; k < 24; k++)
                send_coded(TRAIN_SEQ[k], 1'b0);
            for (int k = 0; k < 8; k++)
                send_coded(FLAG_OCTET[k], 1'b0);
        end
        for (int k = 0; k < 8; k++)
            send_data(octet[k]);
        if (last)
        begin
            for (int k = 7; k >= 0; k--)
                send_coded(FLAG_OCTET[k], 1'b0);
            for (int k = 0; k < RAMP_BITS; k++)
                send_coded(1'b0, k == RAMP_BITS - 1);
            in_frame = 1'b0;
            ones_run = '0;
        end
    endfunction

    function void check_bit(logic lb, logic fe);
        line_bit_t exp_bit;
        if (expected_bits.size() == 0)
        begin
            $error("unexpected result: line_bit=%0b frame_end=%0b", lb, fe);
            errors++;
            return;
        end
        exp_bit = expected_bits.pop_front();
        if (lb !== exp_bit.level)
        begin
            $error("line_bit mismatch: expected %0b, actual %0b", exp_bit.level, lb);
            errors++;
        end
        if (fe !== exp_bit.fend)
        begin
            $error("frame_end mismatch: expected %0b, actual %0b", exp_bit.fend, fe);
            errors++;
        end
    endfunction

    function int pending();
        return expected_bits.size();
    endfunction

endclass

module tb_top;

    localparam int RANDOM_ITEMS = 280;
    localparam int CALM_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 40;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty;
    logic       pop;
    logic       line_bit;
    logic       frame_end;

    logic       no_idle;
    int         pop_stall;

    line_scoreboard sb = new();

    hdlc_stuff_nrzi_tx_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .empty     (empty),
        .pop       (pop),
        .line_bit  (line_bit),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    // monitor: check results first, then expand the accepted octet
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_bit(line_bit, frame_end);
        if (rst_n && push && !full)
            sb.note_octet(data_byte, last_byte);
    end

    // receiver with random stall bursts
    initial
    begin
        pop       = 1'b0;
        pop_stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (pop_stall > 0)
            begin
                pop <= 1'b0;
                pop_stall--;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                pop       <= 1'b0;
                pop_stall = $urandom_range(1, 15) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic send_octet(input logic [7:0] d, input logic l);
        @(negedge clk);
        push      <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic sender_gap(input int n);
        @(negedge clk);
        push      <= 1'b0;
        data_byte <= 8'($urandom);
        last_byte <= 1'($urandom);
        repeat (n - 1)
            @(negedge clk);
    endtask

    // hold off the sender until every expected line bit has come out
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_octet();
        logic [7:0] corner[6] = '{8'hff, 8'h7e, 8'h1f, 8'hf8, 8'h3e, 8'h00};
        case ($urandom_range(0, 9))
            0, 1, 2:    return corner[$urandom_range(0, 5)];
            3, 4, 5:    return 8'($urandom | $urandom);   // ones-heavy, lots of stuffing
            default:    return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [8:0] directed[$];
        int         sent;
        int         len;

        rst_n     = 1'b0;
        push      = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        no_idle   = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // {last, octet}: single-octet frame, stuffing across octets,
        // fifth one on the last data bit, flag-like and alternating data
        directed = '{
            {1'b1, 8'h00},
            {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b1, 8'hff},
            {1'b1, 8'hf8},
            {1'b0, 8'h7e}, {1'b0, 8'h55}, {1'b0, 8'haa}, {1'b0, 8'h1f}, {1'b1, 8'h3e},
            {1'b0, 8'h01}, {1'b0, 8'h80}, {1'b0, 8'hfe}, {1'b1, 8'h7f},
            {1'b0, 8'hf0}, {1'b1, 8'h01}
        };
        foreach (directed[i])
        begin
            if ($urandom_range(0, 2) == 0)
                sender_gap($urandom_range(1, 15));
            send_octet(directed[i][7:0], directed[i][8]);
        end
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
            begin
                if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                    no_idle = 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    sender_gap($urandom_range(1, 15));
                send_octet(pick_octet(), i == len - 1);
                sent++;
            end
        end

        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
